@@ hdl/ecsw_pkg.sv @@
// ----------------------------------------------------------------------------
// ecsw_pkg
// Shared types and constants of the packed character string writer: item
// layouts, request and status codes, and the decoded command passed from
// the front end to the back end.
// ----------------------------------------------------------------------------
package ecsw_pkg;

  localparam int WORD_BITS     = 36;
  localparam int CHAR_W        = 9;
  localparam int COUNT_W       = 12;
  localparam int POS_W         = 6;
  localparam int OUT_ADDR_W    = 24;
  localparam int ADDR_BITS_DEF = 24;
  localparam int FIFO_DEPTH    = 4;

  localparam logic [3:0] CB_NINE = 4'd9;
  localparam logic [3:0] CB_SIX  = 4'd6;
  localparam logic [3:0] CB_FOUR = 4'd4;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_PUT    = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    DT_NINE = 2'd0,
    DT_SIX  = 2'd1,
    DT_FOUR = 2'd2,
    DT_BAD  = 2'd3
  } desc_type_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EXHAUSTED   = 3'd1,
    ST_BAD_TYPE    = 3'd2,
    ST_ODD_CHARNUM = 3'd3,
    ST_POS_OUTSIDE = 3'd4,
    ST_NOT_STARTED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_START_ERR = 3'd1,
    CMD_PUT       = 3'd2,
    CMD_FLUSH     = 3'd3,
    CMD_NOP       = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [WORD_BITS-1:0]  descriptor_word;
    logic [OUT_ADDR_W-1:0] start_address;
    logic [POS_W-1:0]      base_bit_offset;
    logic [CHAR_W-1:0]     char_value;
    logic [WORD_BITS-1:0]  memory_word;
  } req_t;

  typedef struct packed {
    logic                  write_valid;
    logic [OUT_ADDR_W-1:0] write_address;
    logic [WORD_BITS-1:0]  write_data;
    logic [2:0]            status;
    logic [COUNT_W-1:0]    chars_left;
  } res_t;

  typedef struct packed {
    cmd_kind_t             kind;
    status_t               err;
    logic [3:0]            char_bits;
    logic [POS_W-1:0]      pos;
    logic [1:0]            word_inc;
    logic [OUT_ADDR_W-1:0] start_address;
    logic [COUNT_W-1:0]    len;
    logic [CHAR_W-1:0]     char_value;
    logic [WORD_BITS-1:0]  memory_word;
  } cmd_t;

endpackage

@@ hdl/ecsw_front.sv @@
// ----------------------------------------------------------------------------
// ecsw_front
// Classifies incoming items. Start items get their descriptor decoded:
// character size, error checks, start bit position reduced to the word and
// the number of whole words to add to the address.
// ----------------------------------------------------------------------------
module ecsw_front (
  input  ecsw_pkg::req_t req_i,
  output ecsw_pkg::cmd_t cmd_o
);
  import ecsw_pkg::*;

  logic [1:0] dtype;
  logic [2:0] cn;
  logic [2:0] cn_eff;
  logic [3:0] bits;
  logic [5:0] prod;
  logic [6:0] pos_raw;
  logic [6:0] pos_red;
  logic [1:0] inc;

  always_comb begin
    dtype  = req_i.descriptor_word[14:13];
    cn     = req_i.descriptor_word[17:15];
    case (dtype)
      DT_NINE: bits = CB_NINE;
      DT_SIX:  bits = CB_SIX;
      default: bits = CB_FOUR;
    endcase
    // 9-bit character numbers count half characters, so only even values are legal
    cn_eff  = (dtype == DT_NINE) ? {1'b0, cn[2:1]} : cn;
    prod    = {3'b000, cn_eff} * {2'b00, bits};
    pos_raw = {1'b0, req_i.base_bit_offset} + {1'b0, prod};
    if (pos_raw >= 7'(2 * WORD_BITS)) begin
      inc     = 2'd2;
      pos_red = pos_raw - 7'(2 * WORD_BITS);
    end else if (pos_raw >= 7'(WORD_BITS)) begin
      inc     = 2'd1;
      pos_red = pos_raw - 7'(WORD_BITS);
    end else begin
      inc     = 2'd0;
      pos_red = pos_raw;
    end

    cmd_o.kind          = CMD_NOP;
    cmd_o.err           = ST_OK;
    cmd_o.char_bits     = bits;
    cmd_o.pos           = pos_red[POS_W-1:0];
    cmd_o.word_inc      = inc;
    cmd_o.start_address = req_i.start_address;
    cmd_o.len           = req_i.descriptor_word[COUNT_W-1:0];
    cmd_o.char_value    = req_i.char_value;
    cmd_o.memory_word   = req_i.memory_word;

    case (req_i.req_type)
      REQ_START: begin
        if (dtype == DT_BAD) begin
          cmd_o.kind = CMD_START_ERR;
          cmd_o.err  = ST_BAD_TYPE;
        end else if (dtype == DT_NINE && cn[0]) begin
          cmd_o.kind = CMD_START_ERR;
          cmd_o.err  = ST_ODD_CHARNUM;
        end else if (prod >= 6'(WORD_BITS)) begin
          cmd_o.kind = CMD_START_ERR;
          cmd_o.err  = ST_POS_OUTSIDE;
        end else begin
          cmd_o.kind = CMD_START;
        end
      end
      REQ_PUT:   cmd_o.kind = CMD_PUT;
      REQ_FLUSH: cmd_o.kind = CMD_FLUSH;
      default:   cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

@@ hdl/ecsw_fifo.sv @@
// ----------------------------------------------------------------------------
// ecsw_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ecsw_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ecsw_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ecsw_pkg::cmd_t head
);
  import ecsw_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  cmd_t             q_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PTR_W+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("command popped from empty queue");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

@@ hdl/ecsw_back.sv @@
// ----------------------------------------------------------------------------
// ecsw_back
// Executes decoded commands against the string state: loads the state on a
// start, merges characters into the word buffer, writes full or flushed
// words, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ecsw_back #(
  parameter int ADDR_BITS = ecsw_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_empty,
  input  ecsw_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output ecsw_pkg::res_t out_item
);
  import ecsw_pkg::*;

  logic [WORD_BITS-1:0] word_buffer_r, word_buffer_nxt;
  logic [ADDR_BITS-1:0] word_address_r, word_address_nxt;
  logic [POS_W-1:0]     bit_position_r, bit_position_nxt;
  logic [COUNT_W-1:0]   count_left_r, count_left_nxt;
  logic [3:0]           char_bits_r, char_bits_nxt;
  logic                 active_r, active_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_item_r, out_item_nxt;

  logic [WORD_BITS-1:0] aligned, align_mask, field, fmask, merged, low_mask;
  logic [POS_W:0]       pos_sum;
  logic [ADDR_BITS-1:0] addr_inc;

  assign cmd_pop   = !cmd_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign addr_inc  = word_address_r + 1'b1;

  always_comb begin
    // left-align the character at bit 0 of the word (the msb)
    case (char_bits_r)
      CB_SIX: begin
        aligned    = {cmd.char_value[5:0], 30'b0};
        align_mask = {6'h3f, 30'b0};
      end
      CB_FOUR: begin
        aligned    = {cmd.char_value[3:0], 32'b0};
        align_mask = {4'hf, 32'b0};
      end
      default: begin
        aligned    = {cmd.char_value[8:0], 27'b0};
        align_mask = {9'h1ff, 27'b0};
      end
    endcase
    field    = aligned >> bit_position_r;
    fmask    = align_mask >> bit_position_r;
    merged   = (word_buffer_r & ~fmask) | field;
    pos_sum  = {1'b0, bit_position_r} + (POS_W+1)'(char_bits_r);
    low_mask = {WORD_BITS{1'b1}} >> bit_position_r;
  end

  always_comb begin
    word_buffer_nxt  = word_buffer_r;
    word_address_nxt = word_address_r;
    bit_position_nxt = bit_position_r;
    count_left_nxt   = count_left_r;
    char_bits_nxt    = char_bits_r;
    active_nxt       = active_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_item_nxt     = out_item_r;

    if (cmd_pop) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.write_valid   = 1'b0;
      out_item_nxt.write_address = '0;
      out_item_nxt.write_data    = '0;
      out_item_nxt.status        = ST_OK;

      case (cmd.kind)
        CMD_START: begin
          word_address_nxt = ADDR_BITS'(cmd.start_address) + ADDR_BITS'(cmd.word_inc);
          bit_position_nxt = cmd.pos;
          word_buffer_nxt  = (cmd.pos != '0) ? cmd.memory_word : '0;
          char_bits_nxt    = cmd.char_bits;
          count_left_nxt   = cmd.len;
          active_nxt       = 1'b1;
        end
        CMD_START_ERR: begin
          active_nxt          = 1'b0;
          count_left_nxt      = '0;
          out_item_nxt.status = cmd.err;
        end
        CMD_PUT: begin
          if (!active_r) begin
            out_item_nxt.status = ST_NOT_STARTED;
          end else if (count_left_r == '0) begin
            out_item_nxt.status = ST_EXHAUSTED;
          end else begin
            count_left_nxt = count_left_r - 1'b1;
            if (pos_sum >= (POS_W+1)'(WORD_BITS)) begin
              // bits past the word end are dropped, word goes out
              out_item_nxt.write_valid   = 1'b1;
              out_item_nxt.write_address = OUT_ADDR_W'(word_address_r);
              out_item_nxt.write_data    = merged;
              word_address_nxt           = addr_inc;
              bit_position_nxt           = '0;
              word_buffer_nxt            = '0;
            end else begin
              word_buffer_nxt  = merged;
              bit_position_nxt = pos_sum[POS_W-1:0];
            end
          end
        end
        CMD_FLUSH: begin
          if (!active_r) begin
            out_item_nxt.status = ST_NOT_STARTED;
          end else if (bit_position_r != '0) begin
            out_item_nxt.write_valid   = 1'b1;
            out_item_nxt.write_address = OUT_ADDR_W'(word_address_r);
            out_item_nxt.write_data    = (word_buffer_r & ~low_mask) |
                                         (cmd.memory_word & low_mask);
            word_address_nxt           = addr_inc;
            bit_position_nxt           = '0;
            word_buffer_nxt            = '0;
          end
        end
        default: begin
        end
      endcase
      out_item_nxt.chars_left = count_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_buffer_r  <= '0;
      word_address_r <= '0;
      bit_position_r <= '0;
      count_left_r   <= '0;
      char_bits_r    <= CB_NINE;
      active_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      word_buffer_r  <= word_buffer_nxt;
      word_address_r <= word_address_nxt;
      bit_position_r <= bit_position_nxt;
      count_left_r   <= count_left_nxt;
      char_bits_r    <= char_bits_nxt;
      active_r       <= active_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  a_pos_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    bit_position_r < POS_W'(WORD_BITS))
    else $error("bit position outside word");

  a_char_size: assert property (@(posedge clk) disable iff (!rst_n)
    (char_bits_r == CB_NINE) || (char_bits_r == CB_SIX) || (char_bits_r == CB_FOUR))
    else $error("bad character size held");

  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (count_left_r == '0))
    else $error("count left while not started");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.write_valid) |-> (out_item_r.status == ST_OK))
    else $error("word written with error status");

endmodule

@@ hdl/eis_char_string_writer_top.sv @@
// ----------------------------------------------------------------------------
// eis_char_string_writer_top
// Packs 9-, 6- or 4-bit characters into 36-bit words and writes each full
// or flushed word. Front end decodes items, a short queue decouples it from
// the back end that holds the string state.
//
//   port group   dir   handshake        payload
//   in_*         in    in_valid/stall   ecsw_pkg::req_t (start, put, flush)
//   out_*        out   out_valid/stall  ecsw_pkg::res_t (one result per item)
//
// one item per cycle sustained while out_stall stays low, set by the back end's
// combinational shift-and-merge into the word buffer
// an accepted item goes into the command queue; its result is registered once the back end pops it
// in_stall rises only when the 4-entry command queue is full
// out_stall holds the result register, the queue keeps taking items
// reset is synchronous active low; the state comes up not started
// ----------------------------------------------------------------------------
module eis_char_string_writer_top #(
  parameter int ADDR_BITS = ecsw_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ecsw_pkg::req_t in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output ecsw_pkg::res_t out_item
);
  import ecsw_pkg::*;

  cmd_t dec_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  ecsw_front u_front (
    .req_i (in_item),
    .cmd_o (dec_cmd)
  );

  ecsw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (dec_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head_cmd)
  );

  ecsw_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
